// ----- sv/lkv_pkg.sv -----
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the lru key-value cache: beat payloads,
// operation codes, register map and size defaults.
// ----------------------------------------------------------------------------
package lkv_pkg;

	localparam int MAX_ENTRIES_DEF = 16;

	localparam int DATA_W  = 32;
	localparam int LIMIT_W = 5;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	// register index is paddr without the byte bits
	localparam int REG_IDX_W = PADDR_W - 2;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_LIMIT = 1'b0;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	localparam logic signed [DATA_W-1:0] READ_MISS = -32'sd1;

	typedef enum logic {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} opcode_t;

	typedef struct packed {
		opcode_t                   opcode;
		logic signed [DATA_W-1:0]  lookup_key;
		logic signed [DATA_W-1:0]  put_value;
	} lkv_req_t;

	typedef struct packed {
		logic                      hit;
		logic signed [DATA_W-1:0]  read_value;
	} lkv_rsp_t;

endpackage

// ----- sv/lru_key_value_cache_unit.sv -----
// A get result is registered in the reply state after the scan, drain and
// update states; a put goes back to idle after the update. No request is
// taken until idle. The time is set by the key scan, one entry per cycle
// through the single compare unit and the key/value memory read port.
// Reset clears all valid marks and ranks at once and sets entry_limit to 16;
// there is no clearing pass.
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with lru replacement. A sequencer scans
// the entries through one compare unit, then updates ranks and memories.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
	import lkv_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// request channel
	input  logic                req_valid,
	output logic                req_stall,
	input  lkv_req_t            req,
	// response channel
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output lkv_rsp_t            rsp,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int SLOT_W = $clog2(MAX_ENTRIES);
	localparam int RANK_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE,
		ST_REPLY
	} state_t;

	function automatic logic [CNT_W-1:0] clamp_limit(input logic [LIMIT_W-1:0] raw);
		logic [CMP_W-1:0] wide;
		wide = CMP_W'(raw);
		if (wide == '0) begin
			wide = CMP_W'(1);
		end else if (wide > CMP_W'(MAX_ENTRIES)) begin
			wide = CMP_W'(MAX_ENTRIES);
		end
		return CNT_W'(wide);
	endfunction

	state_t                  state_q;
	logic [SLOT_W-1:0]       idx_q;
	lkv_req_t                req_q;
	logic                    rsp_valid_q;
	lkv_rsp_t                rsp_q;
	logic [LIMIT_W-1:0]      limit_q;

	logic [MAX_ENTRIES-1:0]  valid_q;
	logic [RANK_W-1:0]       rank_q [MAX_ENTRIES];

	// scan pipeline stage, aligned with the memory read data
	logic                    cmp_en_s1;
	logic [SLOT_W-1:0]       slot_s1;
	logic                    valid_s1;
	logic [RANK_W-1:0]       rank_s1;
	logic [DATA_W-1:0]       key_rd_s1;
	logic [DATA_W-1:0]       val_rd_s1;

	// scan results
	logic                    hit_q;
	logic [SLOT_W-1:0]       hit_slot_q;
	logic [RANK_W-1:0]       hit_rank_q;
	logic [DATA_W-1:0]       hit_value_q;
	logic [CNT_W-1:0]        count_q;
	logic                    free_found_q;
	logic [SLOT_W-1:0]       free_slot_q;
	logic                    lru_found_q;
	logic [SLOT_W-1:0]       lru_slot_q;
	logic [RANK_W-1:0]       lru_rank_q;

	logic                    req_take;
	logic                    cfg_wr;
	logic                    cfg_sel_limit;
	logic [CNT_W-1:0]        lim_eff;
	logic [CNT_W-1:0]        lim_new;
	logic                    has_room;
	logic                    do_promote;
	logic [SLOT_W-1:0]       tgt_slot;
	logic [CNT_W-1:0]        tgt_orank;
	logic                    key_wr;
	logic                    val_wr;
	logic                    rsp_free;

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// configuration port
	assign pready        = 1'b1;
	assign cfg_sel_limit = (paddr[PADDR_W-1:2] == REG_ENTRY_LIMIT);
	assign cfg_wr        = psel && penable && pwrite && pready && cfg_sel_limit;
	assign prdata        = cfg_sel_limit ? PDATA_W'(limit_q) : '0;
	assign lim_eff       = clamp_limit(limit_q);
	assign lim_new       = clamp_limit(pwdata[LIMIT_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// update decision after the scan
	assign has_room   = (count_q < lim_eff);
	assign do_promote = (state_q == ST_UPDATE) && (hit_q || req_q.opcode == OP_PUT);
	assign key_wr     = (state_q == ST_UPDATE) && (req_q.opcode == OP_PUT) && !hit_q;
	assign val_wr     = (state_q == ST_UPDATE) && (req_q.opcode == OP_PUT);

	always_comb begin
		if (hit_q) begin
			tgt_slot  = hit_slot_q;
			tgt_orank = CNT_W'(hit_rank_q);
		end else if (has_room) begin
			// new entry: every valid entry ages by one
			tgt_slot  = free_slot_q;
			tgt_orank = CNT_W'(MAX_ENTRIES);
		end else begin
			tgt_slot  = lru_slot_q;
			tgt_orank = CNT_W'(lru_rank_q);
		end
	end

	lkv_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (DATA_W)
	) u_key_ram (
		.clk     (clk),
		.wr_en   (key_wr),
		.wr_addr (tgt_slot),
		.wr_data (req_q.lookup_key),
		.rd_addr (idx_q),
		.rd_data (key_rd_s1)
	);

	lkv_ram #(
		.DEPTH (MAX_ENTRIES),
		.WIDTH (DATA_W)
	) u_val_ram (
		.clk     (clk),
		.wr_en   (val_wr),
		.wr_addr (tgt_slot),
		.wr_data (req_q.put_value),
		.rd_addr (idx_q),
		.rd_data (val_rd_s1)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			cmp_en_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// the reply state loads the next beat itself
			if (rsp_valid_q && !rsp_stall && state_q != ST_REPLY) begin
				rsp_valid_q <= 1'b0;
			end
			cmp_en_s1 <= (state_q == ST_SCAN);
			slot_s1   <= idx_q;
			valid_s1  <= valid_q[idx_q];
			rank_s1   <= rank_q[idx_q];
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						req_q   <= req;
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (idx_q == SLOT_W'(MAX_ENTRIES - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= (req_q.opcode == OP_GET) ? ST_REPLY : ST_IDLE;
				end
				ST_REPLY: begin
					if (rsp_free) begin
						rsp_valid_q      <= 1'b1;
						rsp_q.hit        <= hit_q;
						rsp_q.read_value <= hit_q ? hit_value_q : READ_MISS;
						state_q          <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// compare unit: one entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			lru_found_q  <= 1'b0;
			count_q      <= '0;
		end else if (req_take) begin
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			lru_found_q  <= 1'b0;
			count_q      <= '0;
		end else if (cmp_en_s1) begin
			if (valid_s1) begin
				count_q <= count_q + 1'b1;
				if (!hit_q && key_rd_s1 == $unsigned(req_q.lookup_key)) begin
					hit_q       <= 1'b1;
					hit_slot_q  <= slot_s1;
					hit_rank_q  <= rank_s1;
					hit_value_q <= val_rd_s1;
				end
				// the oldest entry holds the highest rank
				if (!lru_found_q || rank_s1 > lru_rank_q) begin
					lru_found_q <= 1'b1;
					lru_slot_q  <= slot_s1;
					lru_rank_q  <= rank_s1;
				end
			end else if (!free_found_q) begin
				free_found_q <= 1'b1;
				free_slot_q  <= slot_s1;
			end
		end
	end

	// valid marks and recency ranks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				rank_q[j] <= '0;
			end
		end else if (do_promote) begin
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (SLOT_W'(j) == tgt_slot) begin
					valid_q[j] <= 1'b1;
					rank_q[j]  <= '0;
				end else if (valid_q[j] && CNT_W'(rank_q[j]) < tgt_orank) begin
					rank_q[j] <= rank_q[j] + 1'b1;
				end
			end
		end else if (cfg_wr) begin
			// keep only the most recent entries within the new limit
			for (int j = 0; j < MAX_ENTRIES; j++) begin
				if (valid_q[j] && CNT_W'(rank_q[j]) >= lim_new) begin
					valid_q[j] <= 1'b0;
					rank_q[j]  <= '0;
				end
			end
		end
	end

`ifndef SYNTHESIS
	a_rsp_from_reply: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == ST_REPLY)
		else $error("response beat raised outside reply");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_q.hit |-> rsp_q.read_value == READ_MISS)
		else $error("miss response without all-ones value");

	a_fill_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) <= int'(lim_eff))
		else $error("more valid entries than the limit");

	a_take_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> state_q == ST_SCAN && idx_q == '0)
		else $error("accepted request did not start a scan");

	a_insert_target: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_UPDATE && req_q.opcode == OP_PUT && !hit_q
		|-> (has_room && free_found_q) || (!has_room && lru_found_q))
		else $error("put miss without a slot to fill");
`endif

endmodule

// ----- sv/lkv_ram.sv -----
// ----------------------------------------------------------------------------
// lkv_ram
// Simple dual-port memory: one write port, one read port with registered
// read data. Contents are undefined until written.
// ----------------------------------------------------------------------------
module lkv_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  logic [WIDTH-1:0]          wr_data,
	input  logic [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [WIDTH-1:0]          rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- tb/tb_lru_key_value_cache_unit.sv -----
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache_unit
// Checks the lru key-value cache against a behavioral copy of its entry table.
// A directed sequence covers the edge keys, overwrites, hits that return -1,
// evictions and limit changes. Random get/put traffic then runs over small
// key pools under several entry limits. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache_unit import lkv_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES      = MAX_ENTRIES_DEF;
	localparam int SETTLE       = 2 * (ENTRIES + 4);
	localparam int LONG_HOLD    = 300;
	localparam int IDLE_LIMIT   = 4000;
	localparam int PHASE_OPS    = 128;
	localparam int POOL_SIZE    = 40;

	localparam logic [PADDR_W-1:0] LIMIT_ADDR = {REG_ENTRY_LIMIT, 2'b00};
	localparam logic [PADDR_W-1:0] SPARE_ADDR = {~REG_ENTRY_LIMIT, 2'b00};

	logic               clk     = 1'b0;
	logic               arst_n  = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	lkv_req_t           req     = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	lkv_rsp_t           rsp;
	logic               psel    = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite  = 1'b0;
	logic [PADDR_W-1:0] paddr   = '0;
	logic [PDATA_W-1:0] pwdata  = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	lru_key_value_cache_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #1 clk = ~clk;

	// cache table as the block should hold it
	logic [DATA_W-1:0]  tbl_key   [ENTRIES];
	logic [DATA_W-1:0]  tbl_val   [ENTRIES];
	logic               tbl_valid [ENTRIES];
	logic [3:0]         tbl_rank  [ENTRIES];
	logic [LIMIT_W-1:0] tbl_limit = LIMIT_RESET;

	lkv_req_t op_backlog [$];
	lkv_rsp_t lookup_due [$];
	logic [DATA_W-1:0] key_pool [POOL_SIZE];

	int fail_count  = 0;
	int idle_cycles = 0;
	bit req_taken   = 1'b0;
	bit req_busy    = 1'b0;
	int req_gap     = 0;
	lkv_req_t req_cur = '0;
	bit rsp_taken   = 1'b0;
	int rsp_hold    = 0;
	bit no_idle     = 1'b0;
	bit long_hold   = 1'b0;

	initial begin
		for (int i = 0; i < ENTRIES; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_rank[i]  = '0;
		end
	end

	function automatic int lru_cap();
		if (tbl_limit == 0)
			return 1;
		if (tbl_limit > ENTRIES)
			return ENTRIES;
		return int'(tbl_limit);
	endfunction

	// make slot the most recent, entries that were newer age by one
	function automatic void lru_promote(int slot);
		logic [3:0] old_rank;
		old_rank = tbl_rank[slot];
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && i != slot && tbl_rank[i] < old_rank)
				tbl_rank[i]++;
		tbl_rank[slot] = '0;
	endfunction

	function automatic void lru_set_limit(logic [LIMIT_W-1:0] value);
		int cap;
		tbl_limit = value;
		cap = lru_cap();
		// the most recent entries survive a lowered limit
		for (int i = 0; i < ENTRIES; i++)
			if (tbl_valid[i] && tbl_rank[i] >= cap) begin
				tbl_valid[i] = 1'b0;
				tbl_rank[i]  = '0;
			end
	endfunction

	function automatic void lru_apply_op(input lkv_req_t op, output bit gives_rsp,
			output lkv_rsp_t res);
		int slot;
		int count;
		slot = -1;
		for (int i = 0; i < ENTRIES; i++)
			if (slot < 0 && tbl_valid[i] && tbl_key[i] == op.lookup_key)
				slot = i;
		gives_rsp      = (op.opcode == OP_GET);
		res.hit        = 1'b0;
		res.read_value = READ_MISS;
		if (op.opcode == OP_GET) begin
			if (slot >= 0) begin
				lru_promote(slot);
				res.hit        = 1'b1;
				res.read_value = tbl_val[slot];
			end
		end else if (slot >= 0) begin
			tbl_val[slot] = op.put_value;
			lru_promote(slot);
		end else begin
			count = 0;
			for (int i = 0; i < ENTRIES; i++)
				count += tbl_valid[i];
			if (count < lru_cap()) begin
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && !tbl_valid[i])
						slot = i;
				for (int i = 0; i < ENTRIES; i++)
					if (tbl_valid[i])
						tbl_rank[i]++;
				tbl_valid[slot] = 1'b1;
				tbl_rank[slot]  = '0;
			end else begin
				// reuse the least recent slot
				for (int i = 0; i < ENTRIES; i++)
					if (slot < 0 && tbl_valid[i] && tbl_rank[i] == count - 1)
						slot = i;
				if (slot >= 0)
					lru_promote(slot);
			end
			if (slot >= 0) begin
				tbl_key[slot] = op.lookup_key;
				tbl_val[slot] = op.put_value;
			end
		end
	endfunction

	function automatic void push_op(opcode_t code, logic [DATA_W-1:0] key,
			logic [DATA_W-1:0] value);
		lkv_req_t op;
		op.opcode     = code;
		op.lookup_key = key;
		op.put_value  = value;
		op_backlog.push_back(op);
	endfunction

	// request side: predict at the accepting edge
	always @(posedge clk) begin
		bit gives_rsp;
		lkv_rsp_t res;
		if (arst_n && req_valid && !req_stall) begin
			lru_apply_op(req, gives_rsp, res);
			if (gives_rsp)
				lookup_due.push_back(res);
			req_taken = 1'b1;
			if ($urandom_range(0, 127) == 0)
				no_idle = !no_idle;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken) begin
				req_taken = 1'b0;
				req_busy  = 1'b0;
				req_gap   = no_idle ? 0 : $urandom_range(0, 6);
			end
			if (!req_busy) begin
				if (req_gap > 0) begin
					req_gap--;
				end else if (op_backlog.size() != 0) begin
					req_cur  = op_backlog.pop_front();
					req_busy = 1'b1;
				end
			end
			req_valid <= req_busy;
			req       <= req_cur;
		end
	end

	// response side
	always @(posedge clk) begin
		lkv_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			rsp_taken = 1'b1;
			if (lookup_due.size() == 0) begin
				fail_count++;
				$display("%0t: result beat with no lookup pending: hit %0b value %0d",
					$time, rsp.hit, rsp.read_value);
			end else begin
				want = lookup_due.pop_front();
				if (rsp.hit !== want.hit) begin
					fail_count++;
					$display("%0t: hit mismatch: expected %0b actual %0b",
						$time, want.hit, rsp.hit);
				end
				if (rsp.read_value !== want.read_value) begin
					fail_count++;
					$display("%0t: read_value mismatch: expected %0d actual %0d",
						$time, want.read_value, rsp.read_value);
				end
			end
		end
	end

	always @(negedge clk) begin
		if (rsp_taken) begin
			rsp_taken = 1'b0;
			rsp_hold  = no_idle ? 0 : $urandom_range(0, 6);
		end
		if (long_hold) begin
			long_hold = 1'b0;
			rsp_hold  = LONG_HOLD;
		end
		if (rsp_hold > 0) begin
			rsp_hold--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(psel && penable && pready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("simulation failed");
		$finish;
	end

	task automatic apb_read(input logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
		logic [PDATA_W-1:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (addr[PADDR_W-1:2] == REG_ENTRY_LIMIT)
			lru_set_limit(data[LIMIT_W-1:0]);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		apb_read(LIMIT_ADDR, rd);
		if (rd[LIMIT_W-1:0] !== tbl_limit) begin
			fail_count++;
			$display("%0t: entry_limit readback: expected %0d actual %0d",
				$time, tbl_limit, rd[LIMIT_W-1:0]);
		end
	endtask

	// puts leave no result, so give the last one time to retire
	task automatic wait_cache_idle();
		while (op_backlog.size() != 0 || req_busy || lookup_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [PDATA_W-1:0] rd;
		logic [PDATA_W-1:0] wdata;
		logic [LIMIT_W-1:0] lim_v;
		lkv_req_t op;
		int pool_n;

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		apb_read(LIMIT_ADDR, rd);
		if (rd[LIMIT_W-1:0] !== tbl_limit) begin
			fail_count++;
			$display("%0t: entry_limit after reset: expected %0d actual %0d",
				$time, tbl_limit, rd[LIMIT_W-1:0]);
		end

		// edge keys and values, overwrite, a hit that returns all ones
		push_op(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
		push_op(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
		push_op(OP_GET, 32'h7fff_ffff, $urandom);
		push_op(OP_GET, 32'h8000_0000, $urandom);
		push_op(OP_GET, 32'h0000_0000, $urandom);
		push_op(OP_PUT, 32'h0000_0000, 32'hffff_ffff);
		push_op(OP_GET, 32'h0000_0000, $urandom);
		push_op(OP_PUT, 32'h7fff_ffff, 32'h1234_5678);
		push_op(OP_GET, 32'h7fff_ffff, $urandom);
		push_op(OP_GET, 32'hffff_ffff, $urandom);
		wait_cache_idle();

		// lowered limit, then eviction order
		apb_write(LIMIT_ADDR, 32'd3);
		push_op(OP_PUT, 32'd11, $urandom);
		push_op(OP_PUT, 32'd22, $urandom);
		push_op(OP_PUT, 32'd33, $urandom);
		push_op(OP_PUT, 32'd44, $urandom);
		push_op(OP_GET, 32'd11, $urandom);
		push_op(OP_GET, 32'd22, $urandom);
		push_op(OP_PUT, 32'd55, $urandom);
		push_op(OP_GET, 32'd33, $urandom);
		push_op(OP_GET, 32'd44, $urandom);
		push_op(OP_GET, 32'd55, $urandom);
		push_op(OP_GET, 32'd22, $urandom);
		wait_cache_idle();

		for (int p = 0; p < 11; p++) begin
			case (p)
				0: lim_v = 5'd0;
				1: lim_v = 5'd1;
				2: lim_v = 5'd2;
				3: lim_v = 5'd31;
				4: lim_v = 5'd17;
				5: lim_v = 5'd16;
				6: lim_v = 5'd7;
				7: lim_v = 5'd4;
				8: lim_v = 5'($urandom_range(1, ENTRIES));
				9: lim_v = 5'd16;
				default: lim_v = 5'($urandom_range(0, 31));
			endcase
			wdata = $urandom;
			if ($urandom_range(0, 1))
				wdata[PDATA_W-1:LIMIT_W] = '0;
			wdata[LIMIT_W-1:0] = lim_v;
			apb_write(LIMIT_ADDR, wdata);
			// an address past the register map must not disturb the limit
			if (p == 4)
				apb_write(SPARE_ADDR, $urandom);

			pool_n = lru_cap() + $urandom_range(1, 6);
			for (int k = 0; k < PHASE_OPS; k++) begin
				// sender waits for every lookup to come back mid-phase
				if (p == 8 && k == PHASE_OPS / 2)
					wait_cache_idle();
				op.opcode     = $urandom_range(0, 1) ? OP_PUT : OP_GET;
				op.lookup_key = ($urandom_range(0, 9) == 0) ? $urandom
					: key_pool[$urandom_range(0, pool_n - 1)];
				op.put_value  = $urandom;
				op_backlog.push_back(op);
			end
			// receiver holds off while the backlog keeps offering beats
			if (p == 5)
				long_hold = 1'b1;
			wait_cache_idle();
		end

		if (lookup_due.size() != 0) begin
			fail_count++;
			$display("%0t: %0d lookup results never arrived", $time, lookup_due.size());
		end
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
sv/lkv_pkg.sv
sv/lkv_ram.sv
sv/lru_key_value_cache_unit.sv
tb/tb_lru_key_value_cache_unit.sv
